// File: rtl/tid_pkg.sv
// Package for the timed instruction dispatch controller.
// Holds widths, opcode, read status, result, failure and cfg codes, item/result types.
// No dependencies.
package tid_pkg;

	localparam int TickWidth    = 32;
	localparam int TimeWidth    = 32;
	localparam int RunLenWidth  = 32;
	localparam int CmpWidth     = 64;
	localparam int CfgDataWidth = 32;

	localparam int InDataWidth  = 40;
	localparam int OutDataWidth = 48;

	localparam logic [1:0] OpTick  = 2'd0;
	localparam logic [1:0] OpStart = 2'd1;
	localparam logic [1:0] OpAbort = 2'd2;
	localparam logic [1:0] OpNop   = 2'd3;

	localparam logic [1:0] RdAvailable = 2'd0;
	localparam logic [1:0] RdUnderrun  = 2'd1;
	localparam logic [1:0] RdEnd       = 2'd2;
	localparam logic [1:0] RdCorrupt   = 2'd3;

	localparam logic [1:0] ResContinue = 2'd0;
	localparam logic [1:0] ResComplete = 2'd1;
	localparam logic [1:0] ResFailed   = 2'd2;

	localparam logic [2:0] FcNone        = 3'd0;
	localparam logic [2:0] FcNotPrepared = 3'd1;
	localparam logic [2:0] FcMeasurement = 3'd2;
	localparam logic [2:0] FcLate        = 3'd3;
	localparam logic [2:0] FcOperation   = 3'd4;
	localparam logic [2:0] FcConsume     = 3'd5;
	localparam logic [2:0] FcUnderrun    = 3'd6;
	localparam logic [2:0] FcCorrupt     = 3'd7;

	localparam logic CfgRunLength = 1'b0;
	localparam logic CfgProfile   = 1'b1;

	typedef struct packed {
		logic [1:0]           opcode;
		logic                 measurement_ok;
		logic [1:0]           instr_status;
		logic [TimeWidth-1:0] instruction_time;
		logic                 operation_ok;
		logic                 consume_ok;
	} item_t;

	typedef struct packed {
		logic [1:0]           tick_result;
		logic [2:0]           failure_code;
		logic [TimeWidth-1:0] tick_now;
		logic                 dispatch_now;
		logic                 dispatch_profiled;
		logic                 terminal_event;
		logic                 start_accepted;
	} result_t;

endpackage

// File: rtl/timed_instruction_dispatch_fsm.sv
// Timed instruction dispatch controller, top level.
// Depends on tid_pkg for codes, widths and item/result types.
//
// Usage:
// Commands enter on the s_axis channel (opcode in tuser, adapter results in
// tdata); one result leaves on the m_axis channel for every command.
// The cfg channel writes run_length (index 0) and profile_request (index 1);
// cfg_ready is always high. Write configuration only while no command is
// in flight.
// Order: an accepted command lands in an input register and its result is
// then computed into the output register once that register can take it; the
// result is offered from the output register.
// Throughput: one command per cycle while the output is not stalled; the run state updates once per item.
// Reset: state returns to idle, counter, latch and config registers clear, both
// register stages empty.
// Stall: when m_axis_tready is low the output register holds its result, the
// input register fills, and s_axis_tready drops until the output drains.
module timed_instruction_dispatch_fsm (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// measurement_ok, instr_status[2], instruction_time[32], operation_ok, consume_ok, pad
	input  logic [tid_pkg::InDataWidth-1:0]   s_axis_tdata,
	// opcode[2]
	input  logic [1:0]                        s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// tick_result[2], failure_code[3], tick_now[32], dispatch_now, dispatch_profiled,
	// terminal_event, start_accepted, pad
	output logic [tid_pkg::OutDataWidth-1:0]  m_axis_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_index,
	input  logic [tid_pkg::CfgDataWidth-1:0]  cfg_data
);

	localparam logic [1:0] StIdle     = 2'd0;
	localparam logic [1:0] StReady    = 2'd1;
	localparam logic [1:0] StComplete = 2'd2;
	localparam logic [1:0] StFailed   = 2'd3;

	logic                              valid_s1;
	tid_pkg::item_t                    item_s1;
	logic                              advance;

	logic                              out_valid_q;
	tid_pkg::result_t                  result_q;

	logic [tid_pkg::RunLenWidth-1:0]   run_length_q;
	logic                              profile_req_q;
	logic [1:0]                        state_q;
	logic [tid_pkg::TickWidth-1:0]     tick_q;
	logic [tid_pkg::RunLenWidth-1:0]   ticks_in_run_q;
	logic [2:0]                        latch_q;
	logic                              stream_done_q;
	logic                              profiling_q;

	logic [1:0]                        state_d;
	logic [tid_pkg::TickWidth-1:0]     tick_d;
	logic [tid_pkg::RunLenWidth-1:0]   ticks_in_run_d;
	logic [2:0]                        latch_d;
	logic                              stream_done_d;
	logic                              profiling_d;
	logic                              start_ok;
	tid_pkg::result_t                  result_d;

	logic [tid_pkg::TickWidth-1:0]     tick_inc;
	logic [tid_pkg::CmpWidth-1:0]      tick_ext;
	logic [tid_pkg::CmpWidth-1:0]      time_ext;
	logic [tid_pkg::CmpWidth-1:0]      len_ext;
	logic [1:0]                        rstat;
	logic                              fail;
	logic [2:0]                        fail_code;
	logic                              dispatched;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(tid_pkg::OutDataWidth - 41){1'b0}},
		result_q.start_accepted, result_q.terminal_event, result_q.dispatch_profiled,
		result_q.dispatch_now, result_q.tick_now, result_q.failure_code,
		result_q.tick_result};

	assign tick_inc = tick_q + {{(tid_pkg::TickWidth - 1){1'b0}}, 1'b1};
	assign tick_ext = tid_pkg::CmpWidth'(tick_inc);
	assign time_ext = tid_pkg::CmpWidth'(item_s1.instruction_time);
	assign len_ext  = tid_pkg::CmpWidth'(ticks_in_run_q);
	assign rstat    = stream_done_q ? tid_pkg::RdEnd : item_s1.instr_status;

	always_comb begin
		fail       = 1'b0;
		fail_code  = tid_pkg::FcNone;
		dispatched = 1'b0;
		if (!item_s1.measurement_ok) begin
			fail      = 1'b1;
			fail_code = tid_pkg::FcMeasurement;
		end else begin
			case (rstat)
				tid_pkg::RdAvailable: begin
					if (time_ext < tick_ext) begin
						fail      = 1'b1;
						fail_code = tid_pkg::FcLate;
					end else if (time_ext == tick_ext) begin
						if (!item_s1.operation_ok) begin
							fail      = 1'b1;
							fail_code = tid_pkg::FcOperation;
						end else if (!item_s1.consume_ok) begin
							fail      = 1'b1;
							fail_code = tid_pkg::FcConsume;
						end else begin
							dispatched = 1'b1;
						end
					end
				end
				tid_pkg::RdUnderrun: begin
					fail      = 1'b1;
					fail_code = tid_pkg::FcUnderrun;
				end
				tid_pkg::RdCorrupt: begin
					fail      = 1'b1;
					fail_code = tid_pkg::FcCorrupt;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d        = state_q;
		tick_d         = tick_q;
		ticks_in_run_d = ticks_in_run_q;
		latch_d        = latch_q;
		stream_done_d  = stream_done_q;
		profiling_d    = profiling_q;
		start_ok       = 1'b0;
		result_d       = '0;
		result_d.tick_result = tid_pkg::ResContinue;
		case (item_s1.opcode)
			tid_pkg::OpStart: begin
				if (run_length_q != '0) begin
					start_ok       = 1'b1;
					ticks_in_run_d = run_length_q;
					tick_d         = '0;
					latch_d        = tid_pkg::FcNone;
					state_d        = StReady;
					stream_done_d  = 1'b0;
					profiling_d    = profile_req_q;
				end
			end
			tid_pkg::OpAbort: begin
				state_d = StIdle;
			end
			tid_pkg::OpTick: begin
				case (state_q)
					StComplete: result_d.tick_result = tid_pkg::ResComplete;
					StFailed:   result_d.tick_result = tid_pkg::ResFailed;
					StReady: begin
						tick_d = tick_inc;
						if (fail) begin
							if (latch_q == tid_pkg::FcNone) begin
								latch_d = fail_code;
							end
							state_d                 = StFailed;
							result_d.tick_result    = tid_pkg::ResFailed;
							result_d.terminal_event = 1'b1;
						end else begin
							if (item_s1.measurement_ok && rstat == tid_pkg::RdEnd) begin
								stream_done_d = 1'b1;
							end
							if (tick_ext == len_ext) begin
								state_d                 = StComplete;
								result_d.tick_result    = tid_pkg::ResComplete;
								result_d.terminal_event = 1'b1;
							end
						end
						result_d.dispatch_now      = dispatched;
						result_d.dispatch_profiled = dispatched && profiling_q;
					end
					default: begin
						if (latch_q == tid_pkg::FcNone) begin
							latch_d = tid_pkg::FcNotPrepared;
						end
						state_d                 = StFailed;
						result_d.tick_result    = tid_pkg::ResFailed;
						result_d.terminal_event = 1'b1;
					end
				endcase
			end
			default: ;
		endcase
		result_d.failure_code   = latch_d;
		result_d.tick_now       = tid_pkg::TimeWidth'(tick_d);
		result_d.start_accepted = start_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.opcode           <= s_axis_tuser;
			item_s1.measurement_ok   <= s_axis_tdata[0];
			item_s1.instr_status     <= s_axis_tdata[2:1];
			item_s1.instruction_time <= s_axis_tdata[34:3];
			item_s1.operation_ok     <= s_axis_tdata[35];
			item_s1.consume_ok       <= s_axis_tdata[36];
		end
		if (advance) begin
			result_q <= result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			run_length_q   <= '0;
			profile_req_q  <= 1'b0;
			state_q        <= StIdle;
			tick_q         <= '0;
			ticks_in_run_q <= '0;
			latch_q        <= tid_pkg::FcNone;
			stream_done_q  <= 1'b0;
			profiling_q    <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready && cfg_index == tid_pkg::CfgRunLength) begin
				run_length_q <= cfg_data;
			end
			if (cfg_valid && cfg_ready && cfg_index == tid_pkg::CfgProfile) begin
				profile_req_q <= cfg_data[0];
			end else if (advance && start_ok) begin
				profile_req_q <= 1'b0;
			end
			if (advance) begin
				state_q        <= state_d;
				tick_q         <= tick_d;
				ticks_in_run_q <= ticks_in_run_d;
				latch_q        <= latch_d;
				stream_done_q  <= stream_done_d;
				profiling_q    <= profiling_d;
			end
		end
	end

endmodule

// File: sim/timed_instruction_dispatch_fsm_tb.sv
// Testbench for the timed instruction dispatch controller: directed runs, then random
// runs and noise, checked against a cycle-free model of the run state machine.
// Depends on tid_pkg and the timed_instruction_dispatch_fsm top level.
module timed_instruction_dispatch_fsm_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ItemTarget = 1350;
	localparam int unsigned CalmItems  = 200;
	localparam int unsigned CycleLimit = 300000;

	typedef enum logic [1:0] {RunIdle, RunReady, RunComplete, RunFailed} run_state_t;

	class dispatch_checker;
		logic [tid_pkg::RunLenWidth-1:0] run_length_reg;
		logic                            profile_req;
		run_state_t                      run_state;
		logic [tid_pkg::TickWidth-1:0]   tick_cnt;
		logic [tid_pkg::RunLenWidth-1:0] ticks_in_run;
		logic [2:0]                      fail_latch;
		bit                              stream_done;
		bit                              profiling;
		tid_pkg::result_t                awaited_results[$];
		int unsigned                     errors;

		function new();
			run_length_reg = '0;
			profile_req    = 1'b0;
			run_state      = RunIdle;
			tick_cnt       = '0;
			ticks_in_run   = '0;
			fail_latch     = tid_pkg::FcNone;
			stream_done    = 1'b0;
			profiling      = 1'b0;
			errors         = 0;
		endfunction

		function void write_reg(logic idx, logic [tid_pkg::CfgDataWidth-1:0] val);
			if (idx == tid_pkg::CfgRunLength)
				run_length_reg = val;
			else
				profile_req = val[0];
		endfunction

		function void note_command(tid_pkg::item_t it);
			tid_pkg::result_t r;
			logic [1:0]       rs;
			logic [2:0]       fc;
			r  = '0;
			fc = tid_pkg::FcNone;
			case (it.opcode)
				tid_pkg::OpStart: begin
					if (run_length_reg != 0) begin
						ticks_in_run     = run_length_reg;
						tick_cnt         = '0;
						fail_latch       = tid_pkg::FcNone;
						run_state        = RunReady;
						stream_done      = 1'b0;
						profiling        = profile_req;
						profile_req      = 1'b0;
						r.start_accepted = 1'b1;
					end
				end
				tid_pkg::OpAbort: run_state = RunIdle;
				tid_pkg::OpTick: begin
					if (run_state == RunComplete) begin
						r.tick_result = tid_pkg::ResComplete;
					end else if (run_state == RunFailed) begin
						r.tick_result = tid_pkg::ResFailed;
					end else if (run_state == RunIdle) begin
						fc = tid_pkg::FcNotPrepared;
					end else begin
						tick_cnt = tick_cnt + 1'b1;
						rs = stream_done ? tid_pkg::RdEnd : it.instr_status;
						if (!it.measurement_ok) begin
							fc = tid_pkg::FcMeasurement;
						end else if (rs == tid_pkg::RdAvailable) begin
							if (it.instruction_time < tick_cnt)
								fc = tid_pkg::FcLate;
							else if (it.instruction_time == tick_cnt) begin
								if (!it.operation_ok)
									fc = tid_pkg::FcOperation;
								else if (!it.consume_ok)
									fc = tid_pkg::FcConsume;
								else
									r.dispatch_now = 1'b1;
							end
						end else if (rs == tid_pkg::RdUnderrun) begin
							fc = tid_pkg::FcUnderrun;
						end else if (rs == tid_pkg::RdCorrupt) begin
							fc = tid_pkg::FcCorrupt;
						end else begin
							stream_done = 1'b1;
						end
						if (fc == tid_pkg::FcNone && tick_cnt == ticks_in_run) begin
							run_state        = RunComplete;
							r.tick_result    = tid_pkg::ResComplete;
							r.terminal_event = 1'b1;
						end
					end
					if (fc != tid_pkg::FcNone) begin
						if (fail_latch == tid_pkg::FcNone)
							fail_latch = fc;
						run_state        = RunFailed;
						r.tick_result    = tid_pkg::ResFailed;
						r.terminal_event = 1'b1;
					end
				end
				default: ;
			endcase
			r.failure_code      = fail_latch;
			r.tick_now          = tick_cnt;
			r.dispatch_profiled = r.dispatch_now & profiling;
			awaited_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [tid_pkg::OutDataWidth-1:0] d);
			tid_pkg::result_t want;
			if (awaited_results.size() == 0) begin
				$error("unexpected result transaction %0h", d);
				errors++;
				return;
			end
			want = awaited_results.pop_front();
			compare_field("tick_result", 32'(want.tick_result), 32'(d[1:0]));
			compare_field("failure_code", 32'(want.failure_code), 32'(d[4:2]));
			compare_field("tick_now", want.tick_now, d[36:5]);
			compare_field("dispatch_now", 32'(want.dispatch_now), 32'(d[37]));
			compare_field("dispatch_profiled", 32'(want.dispatch_profiled), 32'(d[38]));
			compare_field("terminal_event", 32'(want.terminal_event), 32'(d[39]));
			compare_field("start_accepted", 32'(want.start_accepted), 32'(d[40]));
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction
	endclass

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	logic [tid_pkg::InDataWidth-1:0]  s_axis_tdata = '0;
	logic [1:0]                       s_axis_tuser = '0;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b1;
	logic [tid_pkg::OutDataWidth-1:0] m_axis_tdata;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic                             cfg_index = 1'b0;
	logic [tid_pkg::CfgDataWidth-1:0] cfg_data = '0;

	dispatch_checker sb = new();
	int unsigned     items_sent = 0;
	int unsigned     ready_hold = 0;
	int unsigned     cycles = 0;

	timed_instruction_dispatch_fsm u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
		if (ready_hold != 0)
			ready_hold--;
		else if (items_sent < ItemTarget - CalmItems && $urandom_range(0, 5) == 0)
			ready_hold = $urandom_range(1, 5);
		m_axis_tready <= (ready_hold == 0);
	end

	initial begin
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("** timed_instruction_dispatch_fsm: FAILED **");
		$finish;
	end

	task automatic send_cmd(input tid_pkg::item_t it);
		if (items_sent < ItemTarget - CalmItems && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= it.opcode;
		s_axis_tdata  <= {3'b000, it.consume_ok, it.operation_ok, it.instruction_time,
			it.instr_status, it.measurement_ok};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_command(it);
		items_sent++;
	endtask

	task automatic write_reg(input logic idx, input logic [tid_pkg::CfgDataWidth-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic tid_pkg::item_t random_item(input logic [1:0] op);
		tid_pkg::item_t it;
		it.opcode           = op;
		it.measurement_ok   = 1'($urandom_range(0, 1));
		it.instr_status     = 2'($urandom_range(0, 3));
		it.instruction_time = $urandom;
		it.operation_ok     = 1'($urandom_range(0, 1));
		it.consume_ok       = 1'($urandom_range(0, 1));
		return it;
	endfunction

	task automatic tick(input logic meas, input logic [1:0] rs, input logic [31:0] itime,
			input logic op_ok, input logic cons_ok);
		tid_pkg::item_t it;
		it.opcode           = tid_pkg::OpTick;
		it.measurement_ok   = meas;
		it.instr_status     = rs;
		it.instruction_time = itime;
		it.operation_ok     = op_ok;
		it.consume_ok       = cons_ok;
		send_cmd(it);
	endtask

	task automatic command(input logic [1:0] op);
		send_cmd(random_item(op));
	endtask

	task automatic directed_checks();
		tick(1'b1, tid_pkg::RdAvailable, 32'd1, 1'b1, 1'b1);
		drain();
		write_reg(tid_pkg::CfgRunLength, 32'd0);
		write_reg(tid_pkg::CfgProfile, 32'd1);
		cfg_valid <= 1'b0;
		command(tid_pkg::OpStart);
		drain();
		write_reg(tid_pkg::CfgRunLength, 32'd4);
		cfg_valid <= 1'b0;
		command(tid_pkg::OpStart);
		tick(1'b1, tid_pkg::RdAvailable, 32'd1, 1'b1, 1'b1);
		tick(1'b1, tid_pkg::RdAvailable, 32'hFFFF_FFFF, 1'b1, 1'b1);
		tick(1'b1, tid_pkg::RdEnd, 32'd0, 1'b1, 1'b1);
		tick(1'b1, tid_pkg::RdCorrupt, 32'd0, 1'b0, 1'b0);
		tick(1'b1, tid_pkg::RdAvailable, 32'd5, 1'b1, 1'b1);
		command(tid_pkg::OpNop);
		command(tid_pkg::OpAbort);
		drain();
		write_reg(tid_pkg::CfgRunLength, 32'hFFFF_FFFF);
		cfg_valid <= 1'b0;
		command(tid_pkg::OpStart);
		tick(1'b1, tid_pkg::RdAvailable, 32'd0, 1'b1, 1'b1);
		tick(1'b1, tid_pkg::RdAvailable, 32'd2, 1'b1, 1'b1);
		command(tid_pkg::OpStart);
		tick(1'b0, tid_pkg::RdAvailable, 32'd1, 1'b1, 1'b1);
		command(tid_pkg::OpStart);
		tick(1'b1, tid_pkg::RdAvailable, 32'd1, 1'b0, 1'b1);
		command(tid_pkg::OpStart);
		tick(1'b1, tid_pkg::RdAvailable, 32'd1, 1'b1, 1'b0);
		command(tid_pkg::OpStart);
		tick(1'b1, tid_pkg::RdUnderrun, 32'd1, 1'b1, 1'b1);
		command(tid_pkg::OpStart);
		tick(1'b1, tid_pkg::RdCorrupt, 32'd1, 1'b1, 1'b1);
		command(tid_pkg::OpAbort);
		tick(1'b1, tid_pkg::RdAvailable, 32'd1, 1'b1, 1'b1);
	endtask

	task automatic run_sequence(input logic [31:0] len);
		logic [31:0]    t;
		logic [31:0]    due;
		int unsigned    n_ticks;
		int unsigned    k;
		tid_pkg::item_t it;
		command(tid_pkg::OpStart);
		t       = '0;
		due     = $urandom_range(1, 4);
		n_ticks = (len <= 40) ? len + $urandom_range(0, 3) : $urandom_range(5, 30);
		for (k = 0; k < n_ticks; k++) begin
			t  = t + 1;
			it = random_item(tid_pkg::OpTick);
			it.measurement_ok   = 1'b1;
			it.instr_status     = tid_pkg::RdAvailable;
			it.instruction_time = due;
			it.operation_ok     = 1'b1;
			it.consume_ok       = 1'b1;
			if ($urandom_range(0, 24) == 0) begin
				case ($urandom_range(0, 8))
					0: it.measurement_ok = 1'b0;
					1: it.instr_status = tid_pkg::RdUnderrun;
					2: it.instr_status = tid_pkg::RdCorrupt;
					3: it.instr_status = tid_pkg::RdEnd;
					4: it.instruction_time = t - 1 - ($urandom % t);
					5: begin
						it.instruction_time = t;
						it.operation_ok     = 1'b0;
					end
					6: begin
						it.instruction_time = t;
						it.consume_ok       = 1'b0;
					end
					7: it.instruction_time = $urandom;
					default: it = random_item(tid_pkg::OpTick);
				endcase
			end
			if (t == due)
				due = t + $urandom_range(1, 4);
			send_cmd(it);
			if ($urandom_range(0, 60) == 0)
				command(tid_pkg::OpAbort);
			else if ($urandom_range(0, 60) == 0) begin
				command(tid_pkg::OpStart);
				t   = '0;
				due = $urandom_range(1, 4);
			end
		end
		if ($urandom_range(0, 2) == 0)
			command(tid_pkg::OpAbort);
	endtask

	initial begin
		logic [31:0] len;
		int unsigned sel;
		int unsigned k;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_checks();
		while (items_sent < ItemTarget) begin
			drain();
			sel = $urandom_range(0, 99);
			if (sel < 10)
				len = '0;
			else if (sel < 18)
				len = 32'hFFFF_FFFF;
			else if (sel < 25)
				len = $urandom;
			else
				len = $urandom_range(1, 30);
			write_reg(tid_pkg::CfgRunLength, len);
			if ($urandom_range(0, 4) < 3)
				write_reg(tid_pkg::CfgProfile, $urandom);
			cfg_valid <= 1'b0;
			if ($urandom_range(0, 4) == 0) begin
				for (k = $urandom_range(5, 15); k > 0; k--)
					send_cmd(random_item(2'($urandom_range(0, 3))));
			end else begin
				run_sequence(len);
			end
		end
		drain();
		repeat (6) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("** timed_instruction_dispatch_fsm: PASSED **");
		else
			$display("** timed_instruction_dispatch_fsm: FAILED **");
		$finish;
	end

endmodule

// File: timed_instruction_dispatch_fsm.f
rtl/tid_pkg.sv
rtl/timed_instruction_dispatch_fsm.sv
sim/timed_instruction_dispatch_fsm_tb.sv
